// ===== design/drs_pkg.sv =====
// shared types and constants for the disk request scheduler
package drs_pkg;

  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_DISPATCH = 2'd1;
  localparam logic [1:0] OP_COMPLETE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SEQ   = 2'd3;

  localparam logic [2:0] POL_FIFO  = 3'd0;
  localparam logic [2:0] POL_SSTF  = 3'd1;
  localparam logic [2:0] POL_LOOK  = 3'd2;
  localparam logic [2:0] POL_CLOOK = 3'd3;
  localparam logic [2:0] POL_FSCAN = 3'd4;

  localparam int ID_W = 16;
  localparam int FIELD_W = 16;
  localparam int CNT_W = 7;

  typedef struct packed {
    logic [1:0]         operation;
    logic [FIELD_W-1:0] req_track;
    logic [ID_W-1:0]    req_id;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ID_W-1:0]    out_id;
    logic [FIELD_W-1:0] out_track;
    logic [FIELD_W-1:0] seek_distance;
    logic [CNT_W-1:0]   pending_count;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic start;      // accept op, latch, begin scan if dispatch and not busy
    logic do_remove;  // begin compaction
  } drs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic found;
    logic remove_done;
    logic busy;
  } drs_sts_t;

endpackage

// ===== design/drs_if.sv =====
// valid/ready channel interfaces
interface drs_in_if;
  import drs_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface drs_out_if;
  import drs_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/drs_datapath.sv =====
// request store, scheduler state and sequential selection scan
module drs_datapath #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TRACK_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  drs_pkg::drs_cmd_t  cmd,
  output drs_pkg::drs_sts_t  sts,
  input  drs_pkg::in_word_t  in_word,
  input  logic [2:0]         policy,
  output drs_pkg::out_word_t res
);
  import drs_pkg::*;

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int HW = $clog2(QUEUE_DEPTH + 1);

  logic [TRACK_BITS-1:0] trk_mem [QUEUE_DEPTH];
  logic [ID_W-1:0]       id_mem  [QUEUE_DEPTH];
  logic                  bank_mem[QUEUE_DEPTH];

  // registered read port and write port
  logic [TRACK_BITS-1:0] rd_trk_r;
  logic [ID_W-1:0]       rd_id_r;
  logic                  rd_bank_r;
  logic [IW-1:0]         rd_addr, wr_addr;
  logic                  wr_en, wr_bank;
  logic [TRACK_BITS-1:0] wr_trk;
  logic [ID_W-1:0]       wr_id;
  logic                  add_go, move_go, add_bank;

  logic [HW-1:0]         held_r, cnt1_r;
  logic                  active_r, busy_r;
  logic [TRACK_BITS-1:0] head_r, prev_r, svc_r;
  logic [15:0]           arr_r;

  // scan state
  logic                  scan_r, rem_r;
  logic [HW-1:0]         idx_r;
  logic [1:0]            pass_r;   // 0 primary, 1 fallback
  logic                  fnd_r;
  logic [IW-1:0]         best_r;
  logic [TRACK_BITS-1:0] btrk_r;
  logic [TRACK_BITS:0]   bdist_r;
  logic [ID_W-1:0]       bid_r;
  logic                  bbank_r;
  logic                  all_r, dir_r;

  logic [TRACK_BITS-1:0] t;
  logic                  b, elig, side_ok, better, want_max;
  logic [TRACK_BITS:0]   d;
  logic [IW-1:0]         ix;
  logic [TRACK_BITS-1:0] hd;
  logic                  bank_has, swap;

  function automatic out_word_t mk_res(logic [1:0] st, logic [ID_W-1:0] id,
                                       logic [FIELD_W-1:0] trk, logic [FIELD_W-1:0] sk,
                                       logic [CNT_W-1:0] cnt);
    return {st, id, trk, sk, cnt};
  endfunction

  assign ix = idx_r[IW-1:0];
  assign t  = rd_trk_r;
  assign b  = rd_bank_r;
  assign hd = head_r;
  assign d  = (t >= hd) ? {1'b0, t - hd} : {1'b0, hd - t};
  assign elig = all_r || (b == active_r);

  always_comb begin
    side_ok  = 1'b1;
    want_max = 1'b0;
    better   = 1'b0;
    case (policy)
      POL_SSTF: better = !fnd_r || (d < bdist_r);
      POL_LOOK, POL_FSCAN, POL_CLOOK: begin
        if (policy == POL_CLOOK || dir_r) begin
          side_ok  = (pass_r == 2'd0) ? (t >= hd) : 1'b1;
          want_max = (pass_r != 2'd0) && (policy != POL_CLOOK);
        end else begin
          side_ok  = (pass_r == 2'd0) ? (t <= hd) : 1'b1;
          want_max = (pass_r == 2'd0);
        end
        better = side_ok && (!fnd_r || (want_max ? (t > btrk_r) : (t < btrk_r)));
      end
      default: better = !fnd_r;
    endcase
    better = better && elig;
  end

  // per-bank occupancy from the bank-one count
  assign bank_has = active_r ? (cnt1_r != '0) : (cnt1_r != held_r);
  assign swap     = (policy == POL_FSCAN) && !bank_has;
  assign add_bank = (policy == POL_FSCAN && busy_r) ? !active_r : active_r;

  assign add_go  = cmd.start && (in_word.operation == OP_ADD) && (held_r < HW'(QUEUE_DEPTH));
  assign move_go = rem_r && (idx_r + 1'b1 < held_r);
  assign wr_en   = add_go || move_go;
  assign wr_addr = add_go ? held_r[IW-1:0] : ix;
  assign wr_trk  = add_go ? TRACK_BITS'(in_word.req_track) : rd_trk_r;
  assign wr_id   = add_go ? in_word.req_id : rd_id_r;
  assign wr_bank = add_go ? add_bank : rd_bank_r;

  // address of the entry needed in the next cycle
  always_comb begin
    rd_addr = '0;
    if (scan_r) begin
      if (idx_r != held_r) rd_addr = IW'(idx_r + 1'b1);
      else if (sts.scan_done) rd_addr = IW'(best_r + 1'b1);
    end else if (rem_r) begin
      rd_addr = IW'(idx_r + 2'd2);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      trk_mem[wr_addr]  <= wr_trk;
      id_mem[wr_addr]   <= wr_id;
      bank_mem[wr_addr] <= wr_bank;
    end
    rd_trk_r  <= trk_mem[rd_addr];
    rd_id_r   <= id_mem[rd_addr];
    rd_bank_r <= bank_mem[rd_addr];
  end

  assign sts.scan_done   = scan_r && (idx_r == held_r) && (fnd_r || pass_r != 2'd0 ||
                           policy == POL_FIFO || policy == POL_SSTF || policy > POL_FSCAN);
  assign sts.found       = fnd_r;
  assign sts.remove_done = rem_r && (idx_r + 1'b1 >= held_r);
  assign sts.busy        = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0; cnt1_r <= '0; active_r <= 1'b0; busy_r <= 1'b0;
      head_r <= '0; prev_r <= '0; svc_r <= '0; arr_r <= '0;
      scan_r <= 1'b0; rem_r <= 1'b0; res <= '0;
    end else if (cmd.start) begin
      case (in_word.operation)
        OP_ADD: begin
          if (!add_go) res <= mk_res(ST_FULL, '0, '0, '0, CNT_W'(held_r));
          else begin
            if (add_bank) cnt1_r <= cnt1_r + 1'b1;
            arr_r  <= arr_r + 16'd1;
            held_r <= held_r + 1'b1;
            res    <= mk_res(ST_OK, '0, '0, '0, CNT_W'(held_r + 1'b1));
          end
        end
        OP_DISPATCH: begin
          if (busy_r) res <= mk_res(ST_SEQ, '0, '0, '0, CNT_W'(held_r));
          else begin
            scan_r <= 1'b1; idx_r <= '0; pass_r <= 2'd0; fnd_r <= 1'b0;
            all_r  <= (policy != POL_FSCAN);
            dir_r  <= swap || (head_r >= prev_r);
            if (swap) begin
              active_r <= !active_r; prev_r <= head_r;
            end
          end
        end
        OP_COMPLETE: begin
          if (!busy_r) res <= mk_res(ST_SEQ, '0, '0, '0, CNT_W'(held_r));
          else begin
            if (svc_r != head_r) prev_r <= head_r;
            head_r <= svc_r; busy_r <= 1'b0;
            res <= mk_res(ST_OK, '0, '0, '0, CNT_W'(held_r));
          end
        end
        default: res <= mk_res(ST_SEQ, '0, '0, '0, CNT_W'(held_r));
      endcase
    end else if (scan_r) begin
      if (idx_r == held_r) begin
        if (sts.scan_done) begin
          scan_r <= 1'b0;
          if (!fnd_r) res <= mk_res(ST_EMPTY, '0, '0, '0, CNT_W'(held_r));
          else begin
            res <= mk_res(ST_OK, bid_r, FIELD_W'(btrk_r), FIELD_W'(bdist_r),
                          CNT_W'(held_r - 1'b1));
            busy_r <= 1'b1; svc_r <= btrk_r;
            cnt1_r <= cnt1_r - HW'(bbank_r);
            rem_r  <= cmd.do_remove;
            idx_r  <= HW'(best_r);
          end
        end else begin
          pass_r <= 2'd1; idx_r <= '0;
        end
      end else begin
        if (better) begin
          fnd_r <= 1'b1; best_r <= ix; btrk_r <= t; bdist_r <= d;
          bid_r <= rd_id_r; bbank_r <= b;
        end
        idx_r <= idx_r + 1'b1;
      end
    end else if (rem_r) begin
      if (idx_r + 1'b1 >= held_r) begin
        rem_r <= 1'b0; held_r <= held_r - 1'b1;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) held_r <= HW'(QUEUE_DEPTH))
    else $error("held count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) !(scan_r && rem_r))
    else $error("scan and compaction overlap");
  assert property (@(posedge clk) disable iff (!rst_n) scan_r |-> !busy_r)
    else $error("scan while busy");
endmodule

// ===== design/drs_ctrl.sv =====
// controller state machine sequencing operations
module drs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  drs_in_if.sink            in_ch,
  drs_out_if.source         out_ch,
  input  drs_pkg::drs_sts_t sts,
  output drs_pkg::drs_cmd_t cmd
);
  import drs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_REM  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       dispatch_go;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign cmd.start    = in_ch.valid && in_ch.ready;
  assign dispatch_go  = (in_ch.data.operation == OP_DISPATCH) && !sts.busy;
  assign cmd.do_remove = (state_r == S_SCAN) && sts.scan_done && sts.found;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (cmd.start) state_nxt = dispatch_go ? S_SCAN : S_OUT;
      S_SCAN: if (sts.scan_done) state_nxt = sts.found ? S_REM : S_OUT;
      S_REM:  if (sts.remove_done) state_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cmd.start |=> !in_ch.ready)
    else $error("accepted while working");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
    else $error("word dropped");
  assert property (@(posedge clk) disable iff (!rst_n) !(in_ch.ready && out_ch.valid))
    else $error("ready with pending word");
endmodule

// ===== design/disk_request_scheduler_top.sv =====
// disk request scheduler top level
// add, complete and rejected ops: result handshake in the cycle after acceptance at the earliest
// dispatch: one or two scan passes over the held entries, then compaction of the entries behind
// the entry taken from position k if one is found, then the result handshake
// one word in flight; input ready again the cycle after the result handshake
// synchronous active-low reset empties the store and clears head, bank and busy state
module disk_request_scheduler_top #(
  parameter int QUEUE_DEPTH = 64,
  parameter int TRACK_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  drs_in_if.sink               in_ch,
  drs_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_wdata
);
  import drs_pkg::*;

  logic [2:0] policy_r;
  drs_cmd_t   cmd;
  drs_sts_t   sts;

  always_ff @(posedge clk) begin
    if (!rst_n) policy_r <= POL_FIFO;
    else if (cfg_we) policy_r <= cfg_wdata;
  end

  drs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .sts(sts), .cmd(cmd)
  );

  drs_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .TRACK_BITS(TRACK_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_word(in_ch.data),
    .policy(policy_r), .res(out_ch.data)
  );
endmodule
